@@ rtl/ilwc_pkg.sv @@
// Shared types, constants and deflate code tables for the LZ77 window copy block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ilwc_pkg;

  localparam int unsigned WindowBytes    = 32768;
  localparam int unsigned BytesPerResult = 8;
  localparam int unsigned QueueDepth     = 2;

  localparam int unsigned SymW   = 9;
  localparam int unsigned LenW   = 9;
  localparam int unsigned DistW  = 16;
  localparam int unsigned DataW  = 64;
  localparam int unsigned CountW = 4;

  localparam logic [SymW-1:0] EndSymbol      = 9'd256;
  localparam logic [SymW-1:0] FirstLenSymbol = 9'd257;
  localparam logic [SymW-1:0] LastLenSymbol  = 9'd285;
  localparam logic [4:0]      DistCodes      = 5'd30;
  localparam logic [7:0]      ByteMask       = 8'hff;

  typedef enum logic [1:0] {
    OpLit  = 2'd0,
    OpEob  = 2'd1,
    OpCopy = 2'd2
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [7:0]      lit;
    logic [LenW-1:0] len;
    logic [DistW-1:0] distance;
  } q_entry_t;

  function automatic logic [LenW-1:0] len_base(input logic [4:0] code);
    logic [LenW-1:0] b;
    unique case (code)
      5'd0:  b = 9'd3;
      5'd1:  b = 9'd4;
      5'd2:  b = 9'd5;
      5'd3:  b = 9'd6;
      5'd4:  b = 9'd7;
      5'd5:  b = 9'd8;
      5'd6:  b = 9'd9;
      5'd7:  b = 9'd10;
      5'd8:  b = 9'd11;
      5'd9:  b = 9'd13;
      5'd10: b = 9'd15;
      5'd11: b = 9'd17;
      5'd12: b = 9'd19;
      5'd13: b = 9'd23;
      5'd14: b = 9'd27;
      5'd15: b = 9'd31;
      5'd16: b = 9'd35;
      5'd17: b = 9'd43;
      5'd18: b = 9'd51;
      5'd19: b = 9'd59;
      5'd20: b = 9'd67;
      5'd21: b = 9'd83;
      5'd22: b = 9'd99;
      5'd23: b = 9'd115;
      5'd24: b = 9'd131;
      5'd25: b = 9'd163;
      5'd26: b = 9'd195;
      5'd27: b = 9'd227;
      5'd28: b = 9'd258;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] len_bits(input logic [4:0] code);
    logic [4:0] t;
    t = code - 5'd4;
    if (code < 5'd8 || code == 5'd28) begin
      return 3'd0;
    end
    return t[4:2];
  endfunction

  function automatic logic [DistW-1:0] dist_base(input logic [4:0] code);
    logic [DistW-1:0] b;
    unique case (code)
      5'd0:  b = 16'd1;
      5'd1:  b = 16'd2;
      5'd2:  b = 16'd3;
      5'd3:  b = 16'd4;
      5'd4:  b = 16'd5;
      5'd5:  b = 16'd7;
      5'd6:  b = 16'd9;
      5'd7:  b = 16'd13;
      5'd8:  b = 16'd17;
      5'd9:  b = 16'd25;
      5'd10: b = 16'd33;
      5'd11: b = 16'd49;
      5'd12: b = 16'd65;
      5'd13: b = 16'd97;
      5'd14: b = 16'd129;
      5'd15: b = 16'd193;
      5'd16: b = 16'd257;
      5'd17: b = 16'd385;
      5'd18: b = 16'd513;
      5'd19: b = 16'd769;
      5'd20: b = 16'd1025;
      5'd21: b = 16'd1537;
      5'd22: b = 16'd2049;
      5'd23: b = 16'd3073;
      5'd24: b = 16'd4097;
      5'd25: b = 16'd6145;
      5'd26: b = 16'd8193;
      5'd27: b = 16'd12289;
      5'd28: b = 16'd16385;
      5'd29: b = 16'd24577;
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [3:0] dist_bits(input logic [4:0] code);
    logic [4:0] t;
    t = code - 5'd2;
    if (code < 5'd4) begin
      return 4'd0;
    end
    return t[4:1];
  endfunction

endpackage

`default_nettype wire

@@ rtl/inflate_lz77_window_copy.sv @@
// Deflate LZ77 back-reference expander: literals and length/distance copies over a
// circular history window, packed into words. Instantiates ilwc_front, ilwc_queue, ilwc_back.
//
// Usage: the input channel (in_valid_i/in_ready_o) takes one decoded symbol word with its
// extra-bit values. The output channel (out_valid_o/out_ready_i) returns packed words of up
// to BYTES_PER_RESULT bytes, first byte in the low bits; last_o marks the final word of a
// symbol and end_of_block_o the word for symbol 256. Invalid length symbols and distance
// codes are consumed without any output word.
// An accepted literal or end marker passes the queue slot, the data stage and the output
// register before it is offered. A copy of length L moves one byte per cycle, while the
// output does not stall, through the read and write ports of the window memory, so a
// longest match of 258 bytes yields 33 words. A two-entry queue lets new words be
// accepted while a copy runs.
// Reset clears the write position and the packer; the window is not swept, and a position
// that has never been written reads as zero. When the receiver stalls, the output word holds,
// the copy engine stops at the next word boundary and the input side stops once the queue
// is full.
`default_nettype none

module inflate_lz77_window_copy #(
  parameter int unsigned WINDOW_BYTES     = ilwc_pkg::WindowBytes,
  parameter int unsigned BYTES_PER_RESULT = ilwc_pkg::BytesPerResult
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ilwc_pkg::SymW-1:0]   symbol_i,
  input  wire logic [4:0]                  length_extra_i,
  input  wire logic [4:0]                  dist_code_i,
  input  wire logic [12:0]                 dist_extra_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [ilwc_pkg::DataW-1:0]       data_o,
  output logic [ilwc_pkg::CountW-1:0]      byte_count_o,
  output logic                             last_o,
  output logic                             end_of_block_o
);
  import ilwc_pkg::*;

  logic     q_full;
  logic     q_push;
  logic     q_empty;
  logic     q_pop;
  q_entry_t q_in;
  q_entry_t q_out;

  ilwc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .symbol_i       (symbol_i),
    .length_extra_i (length_extra_i),
    .dist_code_i    (dist_code_i),
    .dist_extra_i   (dist_extra_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_in)
  );

  ilwc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  ilwc_back #(
    .WINDOW_BYTES     (WINDOW_BYTES),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_out),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_o         (data_o),
    .byte_count_o   (byte_count_o),
    .last_o         (last_o),
    .end_of_block_o (end_of_block_o)
  );

endmodule

`default_nettype wire

@@ rtl/ilwc_front.sv @@
// Front end: accepts symbol words, drops invalid codes and decodes lengths and distances.
// Depends on ilwc_pkg for the code tables and the queue entry type.
`default_nettype none

module ilwc_front (
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ilwc_pkg::SymW-1:0]   symbol_i,
  input  wire logic [4:0]                  length_extra_i,
  input  wire logic [4:0]                  dist_code_i,
  input  wire logic [12:0]                 dist_extra_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output ilwc_pkg::q_entry_t               q_entry_o
);
  import ilwc_pkg::*;

  logic [SymW-1:0]  lcode_full;
  logic [4:0]       lcode;
  logic [2:0]       lnb;
  logic [3:0]       dnb;
  logic [5:0]       lmask;
  logic [13:0]      dmask;
  logic             is_lit;
  logic             is_eob;
  logic             len_ok;
  logic             dist_ok;

  assign lcode_full = symbol_i - FirstLenSymbol;
  assign lcode      = lcode_full[4:0];
  assign lnb        = len_bits(lcode);
  assign dnb        = dist_bits(dist_code_i);
  assign lmask      = (6'd1 << lnb) - 6'd1;
  assign dmask      = (14'd1 << dnb) - 14'd1;

  assign is_lit  = (symbol_i < EndSymbol);
  assign is_eob  = (symbol_i == EndSymbol);
  assign len_ok  = (symbol_i >= FirstLenSymbol) && (symbol_i <= LastLenSymbol);
  assign dist_ok = (dist_code_i < DistCodes);

  always_comb begin
    q_entry_o.lit      = symbol_i[7:0] & ByteMask;
    q_entry_o.len      = len_base(lcode) + LenW'(length_extra_i & lmask[4:0]);
    q_entry_o.distance = dist_base(dist_code_i) + DistW'(dist_extra_i & dmask[12:0]);
    if (is_lit) begin
      q_entry_o.op = OpLit;
    end else if (is_eob) begin
      q_entry_o.op = OpEob;
    end else begin
      q_entry_o.op = OpCopy;
    end
  end

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && (is_lit || is_eob || (len_ok && dist_ok));

endmodule

`default_nettype wire

@@ rtl/ilwc_queue.sv @@
// Short queue of decoded commands between the front end and the copy engine.
// Depends on ilwc_pkg for the entry type and the queue depth.
`default_nettype none

module ilwc_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ilwc_pkg::q_entry_t   entry_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output ilwc_pkg::q_entry_t        entry_o
);
  import ilwc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_entry_t        slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ilwc_back.sv @@
// Copy engine: history window memory, byte issue sequencer, word packer and output register.
// Depends on ilwc_pkg for the queue entry type, op codes and widths.
`default_nettype none

module ilwc_back #(
  parameter int unsigned WINDOW_BYTES     = ilwc_pkg::WindowBytes,
  parameter int unsigned BYTES_PER_RESULT = ilwc_pkg::BytesPerResult
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_empty_i,
  input  wire ilwc_pkg::q_entry_t           q_entry_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ilwc_pkg::DataW-1:0]        data_o,
  output logic [ilwc_pkg::CountW-1:0]       byte_count_o,
  output logic                              last_o,
  output logic                              end_of_block_o
);
  import ilwc_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCopy = 2'b10
  } state_e;

  logic [7:0]        win_mem_q [WINDOW_BYTES];
  logic [7:0]        rd_data_q;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  state_e            st_q, st_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]     src_q, src_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic              wrap_q, wrap_d;

  logic              d_vld_q, d_vld_d;
  logic              d_eob_q, d_eob_d;
  logic              d_lit_q, d_lit_d;
  logic [7:0]        d_litb_q, d_litb_d;
  logic              d_byp_q, d_byp_d;
  logic [7:0]        d_bypb_q, d_bypb_d;
  logic              d_ok_q, d_ok_d;
  logic              d_last_q, d_last_d;
  logic [AW-1:0]     d_wa_q, d_wa_d;

  logic [DataW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] fill_q, fill_d;
  logic              ov_q, ov_d;
  logic [DataW-1:0]  od_q, od_d;
  logic [CountW-1:0] oc_q, oc_d;
  logic              ol_q, ol_d;
  logic              oe_q, oe_d;

  logic [7:0]        d_byte;
  logic              d_done;
  logic              d_fire;
  logic              can_issue;
  logic              iss;
  logic [DataW-1:0]  word;

  always_comb begin
    if (d_lit_q) begin
      d_byte = d_litb_q;
    end else if (d_byp_q) begin
      d_byte = d_bypb_q;
    end else if (d_ok_q) begin
      d_byte = rd_data_q;
    end else begin
      d_byte = '0;
    end
  end

  assign d_done    = d_eob_q || d_last_q || (fill_q == CountW'(BYTES_PER_RESULT - 1));
  assign d_fire    = d_vld_q && (!d_done || !ov_q || out_ready_i);
  assign can_issue = !d_vld_q || d_fire;

  // Issue sequencer: one byte per cycle into the data stage while that stage can take it.
  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    src_d    = src_q;
    wp_d     = wp_q;
    wrap_d   = wrap_q;
    q_pop_o  = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = src_q;
    iss      = 1'b0;
    d_eob_d  = d_eob_q;
    d_lit_d  = d_lit_q;
    d_litb_d = d_litb_q;
    d_byp_d  = d_byp_q;
    d_bypb_d = d_bypb_q;
    d_ok_d   = d_ok_q;
    d_last_d = d_last_q;
    d_wa_d   = d_wa_q;
    unique case (st_q)
      StIdle: begin
        if (!q_empty_i && can_issue) begin
          q_pop_o = 1'b1;
          unique case (q_entry_i.op)
            OpLit: begin
              iss      = 1'b1;
              d_eob_d  = 1'b0;
              d_lit_d  = 1'b1;
              d_litb_d = q_entry_i.lit;
              d_byp_d  = 1'b0;
              d_ok_d   = 1'b0;
              d_last_d = 1'b1;
            end
            OpEob: begin
              iss      = 1'b1;
              d_eob_d  = 1'b1;
              d_lit_d  = 1'b0;
              d_byp_d  = 1'b0;
              d_ok_d   = 1'b0;
              d_last_d = 1'b1;
            end
            OpCopy: begin
              st_d  = StCopy;
              cnt_d = q_entry_i.len;
              src_d = wp_q - q_entry_i.distance[AW-1:0];
            end
            default: begin
              st_d = StIdle;
            end
          endcase
        end
      end
      StCopy: begin
        if (can_issue) begin
          iss      = 1'b1;
          rd_en    = 1'b1;
          d_eob_d  = 1'b0;
          d_lit_d  = 1'b0;
          d_ok_d   = wrap_q || (src_q < wp_q);
          d_byp_d  = d_vld_q && !d_eob_q && (src_q == d_wa_q);
          d_bypb_d = d_byte;
          d_last_d = (cnt_q == LenW'(1));
          src_d    = src_q + 1'b1;
          cnt_d    = cnt_q - 1'b1;
          if (cnt_q == LenW'(1)) begin
            st_d = StIdle;
          end
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
    if (iss && !d_eob_d) begin
      d_wa_d = wp_q;
      wp_d   = wp_q + 1'b1;
      if (wp_q == {AW{1'b1}}) begin
        wrap_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (iss) begin
      d_vld_d = 1'b1;
    end else if (d_fire) begin
      d_vld_d = 1'b0;
    end else begin
      d_vld_d = d_vld_q;
    end
  end

  // Packer and output register.
  always_comb begin
    word = acc_q;
    for (int l = 0; l < BYTES_PER_RESULT; l++) begin
      if (fill_q == CountW'(l)) begin
        word[8*l +: 8] = d_byte;
      end
    end
    acc_d  = acc_q;
    fill_d = fill_q;
    ov_d   = ov_q && !out_ready_i;
    od_d   = od_q;
    oc_d   = oc_q;
    ol_d   = ol_q;
    oe_d   = oe_q;
    if (d_fire) begin
      if (d_eob_q) begin
        ov_d = 1'b1;
        od_d = '0;
        oc_d = '0;
        ol_d = 1'b1;
        oe_d = 1'b1;
      end else if (d_done) begin
        ov_d   = 1'b1;
        od_d   = word;
        oc_d   = fill_q + 1'b1;
        ol_d   = d_last_q;
        oe_d   = 1'b0;
        acc_d  = '0;
        fill_d = '0;
      end else begin
        acc_d  = word;
        fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= win_mem_q[rd_addr];
    end
    if (d_fire && !d_eob_q) begin
      win_mem_q[d_wa_q] <= d_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      cnt_q    <= '0;
      src_q    <= '0;
      wp_q     <= '0;
      wrap_q   <= 1'b0;
      d_vld_q  <= 1'b0;
      d_eob_q  <= 1'b0;
      d_lit_q  <= 1'b0;
      d_byp_q  <= 1'b0;
      d_ok_q   <= 1'b0;
      d_last_q <= 1'b0;
      d_wa_q   <= '0;
      acc_q    <= '0;
      fill_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      src_q    <= src_d;
      wp_q     <= wp_d;
      wrap_q   <= wrap_d;
      d_vld_q  <= d_vld_d;
      d_eob_q  <= d_eob_d;
      d_lit_q  <= d_lit_d;
      d_byp_q  <= d_byp_d;
      d_ok_q   <= d_ok_d;
      d_last_q <= d_last_d;
      d_wa_q   <= d_wa_d;
      acc_q    <= acc_d;
      fill_q   <= fill_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_litb_q <= d_litb_d;
    d_bypb_q <= d_bypb_d;
    od_q     <= od_d;
    oc_q     <= oc_d;
    ol_q     <= ol_d;
    oe_q     <= oe_d;
  end

  assign out_valid_o    = ov_q;
  assign data_o         = od_q;
  assign byte_count_o   = oc_q;
  assign last_o         = ol_q;
  assign end_of_block_o = oe_q;

`ifndef SYNTHESIS
  a_eob_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_block_o) |-> (byte_count_o == '0 && last_o))
    else $error("End-of-block word carries bytes or lacks last.");
  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StCopy) |-> (cnt_q != '0))
    else $error("Copy state entered with zero bytes left.");
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CountW'(BYTES_PER_RESULT))
    else $error("Packer fill count out of range.");
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_vld_q && !d_fire) |=> (d_vld_q && $stable(d_wa_q) && $stable(wp_q)))
    else $error("Stalled data stage lost its byte.");
`endif

endmodule

`default_nettype wire

@@ tb/inflate_lz77_window_copy_tb.sv @@
// Self-checking testbench for inflate_lz77_window_copy: directed rows, then random symbol
// streams, each word checked against a predictor with its own window or a typed row's word.
// Depends on ilwc_pkg and the inflate_lz77_window_copy RTL.
`timescale 1ns / 100ps

module inflate_lz77_window_copy_tb;

  localparam int unsigned PosW       = $clog2(ilwc_pkg::WindowBytes);
  localparam int unsigned MaxMatch   = 258;
  localparam int unsigned RandWords  = 357;
  localparam int unsigned QuietTail  = 60;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned MaxPrinted = 100;

  typedef struct packed {
    logic [ilwc_pkg::DataW-1:0]  data;
    logic [ilwc_pkg::CountW-1:0] count;
    logic                        last;
    logic                        eob;
  } out_word_t;

  typedef enum logic [1:0] {
    RowPredict = 2'd0,
    RowSilent  = 2'd1,
    RowTyped   = 2'd2
  } row_kind_e;

  typedef struct packed {
    logic [8:0]  sym;
    logic [4:0]  lext;
    logic [4:0]  dcode;
    logic [12:0] dext;
    row_kind_e   kind;
    out_word_t   word;
  } stim_row_t;

  localparam int unsigned NumDirRows = 23;

  stim_row_t dir_rows [NumDirRows] = '{
    '{9'd257, 5'd0,  5'd0,  13'd0,    RowTyped,   '{64'h0,  4'd3, 1'b1, 1'b0}},
    '{9'd255, 5'd0,  5'd0,  13'd0,    RowTyped,   '{64'hff, 4'd1, 1'b1, 1'b0}},
    '{9'd0,   5'd31, 5'd31, 13'd8191, RowTyped,   '{64'h0,  4'd1, 1'b1, 1'b0}},
    '{9'd256, 5'd31, 5'd31, 13'd8191, RowTyped,   '{64'h0,  4'd0, 1'b1, 1'b1}},
    '{9'd286, 5'd0,  5'd0,  13'd0,    RowSilent,  '0},
    '{9'd511, 5'd31, 5'd31, 13'd8191, RowSilent,  '0},
    '{9'd257, 5'd0,  5'd30, 13'd0,    RowSilent,  '0},
    '{9'd285, 5'd31, 5'd31, 13'd8191, RowSilent,  '0},
    '{9'd85,  5'd0,  5'd0,  13'd0,    RowTyped,   '{64'h55, 4'd1, 1'b1, 1'b0}},
    '{9'd170, 5'd0,  5'd0,  13'd0,    RowTyped,   '{64'haa, 4'd1, 1'b1, 1'b0}},
    '{9'd258, 5'd0,  5'd1,  13'd0,    RowPredict, '0},
    '{9'd285, 5'd31, 5'd0,  13'd8191, RowPredict, '0},
    '{9'd284, 5'd31, 5'd3,  13'd0,    RowPredict, '0},
    '{9'd265, 5'd31, 5'd4,  13'd8191, RowPredict, '0},
    '{9'd280, 5'd0,  5'd29, 13'd8191, RowPredict, '0},
    '{9'd264, 5'd0,  5'd29, 13'd0,    RowPredict, '0},
    '{9'd1,   5'd0,  5'd0,  13'd0,    RowTyped,   '{64'h01, 4'd1, 1'b1, 1'b0}},
    '{9'd128, 5'd0,  5'd0,  13'd0,    RowTyped,   '{64'h80, 4'd1, 1'b1, 1'b0}},
    '{9'd256, 5'd0,  5'd0,  13'd0,    RowTyped,   '{64'h0,  4'd0, 1'b1, 1'b1}},
    '{9'd270, 5'd3,  5'd13, 13'd31,   RowPredict, '0},
    '{9'd257, 5'd31, 5'd28, 13'd8191, RowPredict, '0},
    '{9'd283, 5'd16, 5'd9,  13'd5,    RowPredict, '0},
    '{9'd262, 5'd0,  5'd31, 13'd0,    RowSilent,  '0}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [ilwc_pkg::SymW-1:0]   symbol_i;
  logic [4:0]                  length_extra_i;
  logic [4:0]                  dist_code_i;
  logic [12:0]                 dist_extra_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [ilwc_pkg::DataW-1:0]  data_o;
  logic [ilwc_pkg::CountW-1:0] byte_count_o;
  logic                        last_o;
  logic                        end_of_block_o;

  logic [7:0]      hist_mem [ilwc_pkg::WindowBytes];
  logic [PosW-1:0] wr_pos;
  out_word_t       window_words_q [$];
  int unsigned     mismatch_cnt;
  bit              bursts_on;
  bit              hold_req;

  inflate_lz77_window_copy dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .symbol_i       (symbol_i),
    .length_extra_i (length_extra_i),
    .dist_code_i    (dist_code_i),
    .dist_extra_i   (dist_extra_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_o         (data_o),
    .byte_count_o   (byte_count_o),
    .last_o         (last_o),
    .end_of_block_o (end_of_block_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) begin
      $display("tb: mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic expand_symbol(input logic [8:0] sym, input logic [4:0] lext,
                               input logic [4:0] dcode, input logic [12:0] dext);
    int unsigned     code;
    int unsigned     nbits;
    int unsigned     len;
    int unsigned     distance;
    int unsigned     fill;
    int unsigned     k;
    logic [PosW-1:0] src;
    logic [7:0]      b;
    out_word_t       w;
    w = '0;
    if (sym < ilwc_pkg::EndSymbol) begin
      hist_mem[wr_pos] = sym[7:0];
      wr_pos = wr_pos + 1'b1;
      w.data[7:0] = sym[7:0];
      w.count = 4'd1;
      w.last = 1'b1;
      window_words_q.push_back(w);
    end else if (sym == ilwc_pkg::EndSymbol) begin
      w.last = 1'b1;
      w.eob = 1'b1;
      window_words_q.push_back(w);
    end else if (sym <= ilwc_pkg::LastLenSymbol && dcode < ilwc_pkg::DistCodes) begin
      code = sym - ilwc_pkg::FirstLenSymbol;
      if (code == 28) begin
        len = MaxMatch;
      end else begin
        len = 3;
        for (k = 0; k < code; k++) begin
          len += 1 << ((k < 8) ? 0 : (k - 4) / 4);
        end
        nbits = (code < 8) ? 0 : (code - 4) / 4;
        len += lext & ((1 << nbits) - 1);
      end
      distance = 1;
      for (k = 0; k < dcode; k++) begin
        distance += 1 << ((k < 4) ? 0 : (k - 2) / 2);
      end
      nbits = (dcode < 4) ? 0 : (dcode - 2) / 2;
      distance += dext & ((1 << nbits) - 1);
      src = wr_pos - distance[PosW-1:0];
      fill = 0;
      for (k = 0; k < len; k++) begin
        b = hist_mem[src];
        hist_mem[wr_pos] = b;
        wr_pos = wr_pos + 1'b1;
        src = src + 1'b1;
        w.data[8*fill +: 8] = b;
        fill++;
        if (fill == ilwc_pkg::BytesPerResult || k + 1 == len) begin
          w.count = fill[ilwc_pkg::CountW-1:0];
          w.last = (k + 1 == len);
          window_words_q.push_back(w);
          w = '0;
          fill = 0;
        end
      end
    end
  endtask

  task automatic send_word(input logic [8:0] sym, input logic [4:0] lext,
                           input logic [4:0] dcode, input logic [12:0] dext);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    symbol_i       <= sym;
    length_extra_i <= lext;
    dist_code_i    <= dcode;
    dist_extra_i   <= dext;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic pick_item(output logic [8:0] sym, output logic [4:0] lext,
                           output logic [4:0] dcode, output logic [12:0] dext);
    int unsigned r;
    r = $urandom_range(0, 99);
    lext = $urandom_range(0, 31);
    dext = $urandom_range(0, 8191);
    dcode = $urandom_range(0, 29);
    if (r < 40) begin
      sym = $urandom_range(0, 255);
    end else if (r < 45) begin
      sym = ilwc_pkg::EndSymbol;
    end else if (r < 85) begin
      if ($urandom_range(0, 9) == 0) begin
        sym = $urandom_range(ilwc_pkg::FirstLenSymbol, ilwc_pkg::LastLenSymbol);
      end else begin
        sym = $urandom_range(ilwc_pkg::FirstLenSymbol, ilwc_pkg::FirstLenSymbol + 11);
      end
      if ($urandom_range(0, 3) != 0) begin
        dcode = $urandom_range(0, 9);
      end
    end else begin
      sym = $urandom_range(0, 511);
      dcode = $urandom_range(0, 31);
    end
  endtask

  initial begin : out_ready_drive
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (bursts_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : out_watch
    out_word_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (window_words_q.size() == 0) begin
        flag_mismatch($sformatf("word %h count %0d with none pending", data_o, byte_count_o));
      end else begin
        w = window_words_q.pop_front();
        if (data_o !== w.data) begin
          flag_mismatch($sformatf("data %h, want %h", data_o, w.data));
        end
        if (byte_count_o !== w.count) begin
          flag_mismatch($sformatf("byte_count %0d, want %0d", byte_count_o, w.count));
        end
        if (last_o !== w.last) begin
          flag_mismatch($sformatf("last %b, want %b", last_o, w.last));
        end
        if (end_of_block_o !== w.eob) begin
          flag_mismatch($sformatf("end_of_block %b, want %b", end_of_block_o, w.eob));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned n0;
    int unsigned sent;
    logic [8:0]  s;
    logic [4:0]  le;
    logic [4:0]  dc;
    logic [12:0] de;
    mismatch_cnt = 0;
    bursts_on = 1'b1;
    hold_req = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    symbol_i       <= '0;
    length_extra_i <= '0;
    dist_code_i    <= '0;
    dist_extra_i   <= '0;
    for (int i = 0; i < ilwc_pkg::WindowBytes; i++) begin
      hist_mem[i] = '0;
    end
    wr_pos = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirRows; i++) begin
      send_word(dir_rows[i].sym, dir_rows[i].lext, dir_rows[i].dcode, dir_rows[i].dext);
      n0 = window_words_q.size();
      expand_symbol(dir_rows[i].sym, dir_rows[i].lext, dir_rows[i].dcode, dir_rows[i].dext);
      if (dir_rows[i].kind != RowPredict) begin
        while (window_words_q.size() > n0) void'(window_words_q.pop_back());
        if (dir_rows[i].kind == RowTyped) begin
          window_words_q.push_back(dir_rows[i].word);
        end
      end
    end

    sent = 0;
    while (sent < RandWords) begin
      pick_item(s, le, dc, de);
      send_word(s, le, dc, de);
      expand_symbol(s, le, dc, de);
      sent++;
      if (sent == 100) begin
        hold_req = 1'b1;
      end
      if (sent == 200) begin
        in_valid_i <= 1'b0;
        while (window_words_q.size() != 0) @(posedge clk_i);
      end
      if (sent == RandWords - QuietTail) begin
        bursts_on = 1'b0;
      end
    end
    in_valid_i <= 1'b0;

    while (window_words_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
